// ===== design/lpmt_pkg.sv =====
package lpmt_pkg;

   localparam int ADDR_W    = 32;
   localparam int PLEN_W    = 6;
   localparam int PORT_W    = 4;
   localparam int TOP_BIT   = 31;
   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 40;

   localparam logic [PLEN_W-1:0] MAX_DEPTH = 6'd32;

   localparam logic ACT_INSERT = 1'b0;
   localparam logic ACT_LOOKUP = 1'b1;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EVAL,
      S_PUSH
   } state_type;

endpackage

// ===== design/lpmt_ram.sv =====
module lpmt_ram
   #(parameter int WIDTH = 61,
     parameter int DEPTH = 4096)
   (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
   );

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/lpm_binary_trie_unit.sv =====
// IPv4 longest-prefix-match table kept as a one-bit-per-level binary trie.
// Request beats (req_*): tuser selects the action, 0 = insert route,
// 1 = look up address. Insert stores hop/port at the node reached by the first
// prefix_length bits of address (lengths above 32 act as 32), allocating
// nodes as needed; if the node pool runs dry the insert answers pool_full and
// stores no route. Lookup returns the route of the deepest matching node.
// Every request yields exactly one response beat on rsp_*.
// Timing: the walk reads one trie node per cycle from the node memory, which
// sets the rate. When the walk ends the unit enters its push state, loads the
// response into the output register once that register is free, and then
// returns to idle, where the next request is accepted. One item is worked
// at a time; the next request is taken while a finished response still waits
// in the output register.
// Reset empties the table (root only, pool counter at one) and drops any
// pending response; no clearing pass is needed. When rsp_tready is low the
// response holds, one further item may finish its walk and then waits for
// the output register to free.
module lpm_binary_trie_unit
   import lpmt_pkg::*;
   #(parameter int NODE_COUNT = 4096,
     parameter int PORT_COUNT = 16)
   (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // address[31:0], prefix_length[37:32], hop_address[69:38], port_in[73:70]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // action[0]
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // found[0], pool_full[1], hop_out[33:2], port_out[37:34]
   output logic [RSP_DATA_W-1:0] rsp_tdata
   );

   localparam int IW     = $clog2(NODE_COUNT);
   localparam int UW     = IW + 1;
   localparam int NODE_W = 2 * IW + 1 + ADDR_W + PORT_W;

   typedef struct packed {
      logic [IW-1:0]     left;
      logic [IW-1:0]     right;
      logic              valid;
      logic [ADDR_W-1:0] hop;
      logic [PORT_W-1:0] port;
   } node_type;

   state_type         state_ff, state_in;
   logic [IW-1:0]     cur_ff, cur_in;
   logic [PLEN_W-1:0] depth_ff, depth_in;
   logic [ADDR_W-1:0] key_ff, key_in;
   logic [PLEN_W-1:0] plen_ff, plen_in;
   logic [ADDR_W-1:0] hop_ff, hop_in;
   logic [PORT_W-1:0] port_ff, port_in;
   logic              act_ff, act_in;
   logic              fresh_ff, fresh_in;
   logic              root_init_ff, root_init_in;
   logic [UW-1:0]     used_ff, used_in;
   logic              best_found_ff, best_found_in;
   logic [ADDR_W-1:0] best_hop_ff, best_hop_in;
   logic [PORT_W-1:0] best_port_ff, best_port_in;
   logic              full_ff, full_in;
   logic              rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic              req_beat;
   logic              rsp_free;
   logic [NODE_W-1:0] rd_data;
   logic              rd_en;
   logic [IW-1:0]     rd_addr;
   logic              wr_en;
   node_type          wr_node;
   node_type          node;
   logic [IW-1:0]     child;
   logic              is_lookup;
   logic              ins_end;
   logic              no_child;
   logic              pool_out;
   logic              eval_done;
   logic              descend;
   logic              alloc;
   logic              ins_full;

   lpmt_ram #(.WIDTH(NODE_W), .DEPTH(NODE_COUNT)) u_node_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (cur_ff),
      .wr_data (wr_node),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // node under evaluation; a freshly allocated or never written root is empty
   always_comb begin
      node      = fresh_ff ? '0 : node_type'(rd_data);
      child     = key_ff[TOP_BIT] ? node.right : node.left;
      no_child  = (child == '0);
      is_lookup = (act_ff == ACT_LOOKUP);
      ins_end   = (depth_ff == plen_ff);
      pool_out  = (used_ff == UW'(NODE_COUNT));
      ins_full  = !ins_end && no_child && pool_out;
      if (is_lookup) begin
         eval_done = (depth_ff == MAX_DEPTH) || no_child;
      end else begin
         eval_done = ins_end || ins_full;
      end
      descend = (state_ff == S_EVAL) && !eval_done && !no_child;
      alloc   = (state_ff == S_EVAL) && !is_lookup && !ins_end && no_child && !pool_out;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_beat) begin
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            if (eval_done) begin
               state_in = S_PUSH;
            end
         end
         S_PUSH: begin
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      req_tready = (state_ff == S_IDLE);
      req_beat   = req_tvalid && req_tready;
      rsp_free   = !rsp_tvalid_ff || rsp_tready;

      rd_en   = req_beat || descend;
      rd_addr = req_beat ? '0 : child;

      wr_node = node;
      wr_en   = 1'b0;
      if (state_ff == S_EVAL && !is_lookup) begin
         if (ins_end) begin
            wr_en         = 1'b1;
            wr_node.valid = 1'b1;
            wr_node.hop   = hop_ff;
            wr_node.port  = port_ff;
         end else if (alloc) begin
            wr_en = 1'b1;
            if (key_ff[TOP_BIT]) begin
               wr_node.right = used_ff[IW-1:0];
            end else begin
               wr_node.left = used_ff[IW-1:0];
            end
         end else if (ins_full && fresh_ff) begin
            wr_en = 1'b1;
         end
      end

      cur_in        = cur_ff;
      depth_in      = depth_ff;
      key_in        = key_ff;
      plen_in       = plen_ff;
      hop_in        = hop_ff;
      port_in       = port_ff;
      act_in        = act_ff;
      fresh_in      = fresh_ff;
      used_in       = used_ff;
      best_found_in = best_found_ff;
      best_hop_in   = best_hop_ff;
      best_port_in  = best_port_ff;
      full_in       = full_ff;
      root_init_in  = root_init_ff || (wr_en && cur_ff == '0);

      if (req_beat) begin
         cur_in        = '0;
         depth_in      = '0;
         key_in        = req_tdata[31:0];
         plen_in       = (req_tdata[37:32] > MAX_DEPTH) ? MAX_DEPTH : req_tdata[37:32];
         hop_in        = req_tdata[69:38];
         if ({28'd0, req_tdata[73:70]} >= 32'(PORT_COUNT)) begin
            port_in = PORT_W'(PORT_COUNT - 1);
         end else begin
            port_in = req_tdata[73:70];
         end
         act_in        = req_tuser;
         fresh_in      = !root_init_ff;
         best_found_in = 1'b0;
         best_hop_in   = '0;
         best_port_in  = '0;
         full_in       = 1'b0;
      end

      if (state_ff == S_EVAL) begin
         if (is_lookup && node.valid) begin
            best_found_in = 1'b1;
            best_hop_in   = node.hop;
            best_port_in  = node.port;
         end
         if (!is_lookup && ins_full) begin
            full_in = 1'b1;
         end
         if (descend) begin
            cur_in   = child;
            depth_in = depth_ff + 1'b1;
            key_in   = key_ff << 1;
            fresh_in = 1'b0;
         end else if (alloc) begin
            cur_in   = used_ff[IW-1:0];
            depth_in = depth_ff + 1'b1;
            key_in   = key_ff << 1;
            fresh_in = 1'b1;
            used_in  = used_ff + 1'b1;
         end
      end

      rsp_data_in   = rsp_data_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      if (state_ff == S_PUSH && rsp_free) begin
         rsp_tvalid_in = 1'b1;
         rsp_data_in   = {2'b00, best_port_ff, best_hop_ff, full_ff, best_found_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         used_ff       <= UW'(1);
         root_init_ff  <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         used_ff       <= used_in;
         root_init_ff  <= root_init_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      cur_ff        <= cur_in;
      depth_ff      <= depth_in;
      key_ff        <= key_in;
      plen_ff       <= plen_in;
      hop_ff        <= hop_in;
      port_ff       <= port_in;
      act_ff        <= act_in;
      fresh_ff      <= fresh_in;
      best_found_ff <= best_found_in;
      best_hop_ff   <= best_hop_in;
      best_port_ff  <= best_port_in;
      full_ff       <= full_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_used_range: assert property (@(posedge clock) disable iff (reset)
      (used_ff != '0) && (used_ff <= UW'(NODE_COUNT)))
      else $error("node pool counter out of range");

   a_wr_allocated: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> ({1'b0, cur_ff} < used_ff))
      else $error("write to an unallocated node");

   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EVAL) |-> (depth_ff <= MAX_DEPTH))
      else $error("walk past depth 32");

   a_fresh_no_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EVAL && fresh_ff) |-> !descend)
      else $error("descent from an empty node");

   a_result_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff |-> !(rsp_data_ff[0] && rsp_data_ff[1]))
      else $error("response both found and pool full");

   a_alloc_counts: assert property (@(posedge clock) disable iff (reset)
      alloc |=> (used_ff == $past(used_ff) + 1'b1))
      else $error("allocation did not advance pool counter");

endmodule

// ===== dv/tb_lpm_binary_trie_unit.sv =====
module tb_lpm_binary_trie_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import lpmt_pkg::*;

   localparam int NODES       = 4096;
   localparam int PORTS       = 16;
   localparam int ITEM_TARGET = 1450;
   localparam int CALM_TAIL   = 200;
   localparam int HOLD_CYCLES = 300;
   localparam int CYCLE_LIMIT = 500000;
   localparam int DRAIN_WAIT  = 40;
   localparam int REGIONS     = 6;

   typedef struct packed {
      logic              action;
      logic [ADDR_W-1:0] address;
      logic [PLEN_W-1:0] prefix_length;
      logic [ADDR_W-1:0] hop_address;
      logic [PORT_W-1:0] port_in;
   } route_req_type;

   typedef struct packed {
      logic              found;
      logic              pool_full;
      logic [ADDR_W-1:0] hop_out;
      logic [PORT_W-1:0] port_out;
   } route_rsp_type;

   class route_model_type;
      int unsigned       left_kid [NODES];
      int unsigned       right_kid [NODES];
      bit                route_set [NODES];
      logic [ADDR_W-1:0] route_hop [NODES];
      logic [PORT_W-1:0] route_port [NODES];
      int unsigned       nodes_used;
      route_rsp_type     pending_answers [$];
      int                errors;

      function void clear_node(int unsigned n);
         left_kid[n] = 0;
         right_kid[n] = 0;
         route_set[n] = 0;
         route_hop[n] = '0;
         route_port[n] = '0;
      endfunction

      function new();
         for (int n = 0; n < NODES; n++) begin
            clear_node(n);
         end
         nodes_used = 1;
         errors = 0;
      endfunction

      function route_rsp_type walk_trie(route_req_type r);
         route_rsp_type     res;
         int unsigned       cur;
         int unsigned       nxt;
         int                depth_lim;
         logic [PORT_W-1:0] stored_port;
         logic              dir_bit;
         res = '0;
         cur = 0;
         if (r.action == ACT_INSERT) begin
            depth_lim = (r.prefix_length > MAX_DEPTH) ? int'(MAX_DEPTH) : int'(r.prefix_length);
            stored_port = (r.port_in >= PORTS) ? PORT_W'(PORTS - 1) : r.port_in;
            for (int d = 0; d < depth_lim; d++) begin
               dir_bit = r.address[TOP_BIT - d];
               nxt = dir_bit ? right_kid[cur] : left_kid[cur];
               if (nxt == 0) begin
                  if (nodes_used >= NODES) begin
                     res.pool_full = 1'b1;
                     return res;
                  end
                  clear_node(nodes_used);
                  nxt = nodes_used;
                  if (dir_bit) right_kid[cur] = nxt;
                  else left_kid[cur] = nxt;
                  nodes_used++;
               end
               cur = nxt;
            end
            route_set[cur] = 1;
            route_hop[cur] = r.hop_address;
            route_port[cur] = stored_port;
         end else begin
            for (int d = 0; d <= int'(MAX_DEPTH); d++) begin
               if (route_set[cur]) begin
                  res.found = 1'b1;
                  res.hop_out = route_hop[cur];
                  res.port_out = route_port[cur];
               end
               if (d == int'(MAX_DEPTH)) break;
               nxt = r.address[TOP_BIT - d] ? right_kid[cur] : left_kid[cur];
               if (nxt == 0) break;
               cur = nxt;
            end
         end
         return res;
      endfunction

      function void note_request(route_req_type r);
         pending_answers.push_back(walk_trie(r));
      endfunction

      task report(string msg);
         if (errors < 25) $display("MISMATCH: %s", msg);
         errors++;
      endtask

      task check_response(logic [RSP_DATA_W-1:0] beat);
         route_rsp_type want;
         route_rsp_type got;
         got.found = beat[0];
         got.pool_full = beat[1];
         got.hop_out = beat[33:2];
         got.port_out = beat[37:34];
         if (pending_answers.size() == 0) begin
            report($sformatf("response beat %h with nothing outstanding", beat));
            return;
         end
         want = pending_answers.pop_front();
         if (got.found !== want.found)
            report($sformatf("found %b, want %b", got.found, want.found));
         if (got.pool_full !== want.pool_full)
            report($sformatf("pool_full %b, want %b", got.pool_full, want.pool_full));
         if (got.hop_out !== want.hop_out)
            report($sformatf("hop_out %h, want %h", got.hop_out, want.hop_out));
         if (got.port_out !== want.port_out)
            report($sformatf("port_out %h, want %h", got.port_out, want.port_out));
      endtask
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   route_model_type route_model = new();
   route_req_type   known_routes [$];
   logic [ADDR_W-1:0] region_base [REGIONS];
   bit              calm = 0;
   bit              hold_request = 0;
   int              cycles = 0;

   always #4 clock = ~clock;

   lpm_binary_trie_unit #(
      .NODE_COUNT(NODES),
      .PORT_COUNT(PORTS)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   function automatic route_req_type make_req(logic act, logic [ADDR_W-1:0] addr,
                                              logic [PLEN_W-1:0] plen,
                                              logic [ADDR_W-1:0] hop,
                                              logic [PORT_W-1:0] prt);
      route_req_type r;
      r.action = act;
      r.address = addr;
      r.prefix_length = plen;
      r.hop_address = hop;
      r.port_in = prt;
      return r;
   endfunction

   function automatic route_req_type random_item(int idx);
      route_req_type     r;
      route_req_type     base;
      logic [ADDR_W-1:0] low_bits;
      logic [ADDR_W-1:0] keep;
      int                pick;
      int                len_pick;
      int                region;
      int                len;
      r.hop_address = $urandom();
      r.port_in = PORT_W'($urandom_range(0, 15));
      r.action = ($urandom_range(0, 99) < 50) ? ACT_LOOKUP : ACT_INSERT;
      low_bits = $urandom();
      pick = $urandom_range(0, 99);
      region = $urandom_range(0, REGIONS - 1);
      r.address = {region_base[region][31:16], low_bits[15:0]};
      if (r.action == ACT_INSERT) begin
         len_pick = $urandom_range(0, 99);
         if (len_pick < 4) r.prefix_length = '0;
         else if (len_pick < 12) r.prefix_length = PLEN_W'($urandom_range(33, 63));
         else if (len_pick < 45) r.prefix_length = PLEN_W'($urandom_range(16, 32));
         else r.prefix_length = PLEN_W'($urandom_range(1, 15));
         // host routes spread over the whole space eat the node pool
         if (idx >= 500 && pick < 30) begin
            r.address = $urandom();
            r.prefix_length = MAX_DEPTH;
         end
      end else begin
         r.prefix_length = PLEN_W'($urandom_range(0, 63));
         if (pick < 55 && known_routes.size() > 0) begin
            base = known_routes[$urandom_range(0, known_routes.size() - 1)];
            len = (base.prefix_length > MAX_DEPTH) ? int'(MAX_DEPTH) : int'(base.prefix_length);
            keep = ~(32'hFFFF_FFFF >> len);
            r.address = (base.address & keep) | (low_bits & ~keep);
         end else if (pick >= 80) begin
            r.address = $urandom();
         end
      end
      return r;
   endfunction

   task send_item(input route_req_type r);
      int gap;
      if (!calm && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 5);
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata <= {6'b0, r.port_in, r.hop_address, r.prefix_length, r.address};
      req_tuser <= r.action;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      route_model.note_request(r);
      if (r.action == ACT_INSERT) known_routes.push_back(r);
      @(negedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) route_model.check_response(rsp_tdata);
   end

   initial begin
      int stall_left;
      stall_left = 0;
      rsp_tready = 1'b0;
      wait (reset === 1'b0);
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 0;
            stall_left = HOLD_CYCLES;
         end else if (stall_left == 0 && !calm && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 5);
         end
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      route_req_type directed [$];
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = ACT_INSERT;
      for (int k = 0; k < REGIONS; k++) region_base[k] = $urandom();

      directed.push_back(make_req(ACT_LOOKUP, 32'h0000_0000, 6'd0, 32'h0, 4'd0));
      directed.push_back(make_req(ACT_LOOKUP, 32'hFFFF_FFFF, 6'd63, 32'hFFFF_FFFF, 4'd15));
      directed.push_back(make_req(ACT_INSERT, 32'h0000_0000, 6'd0, 32'h0101_0101, 4'd1));
      directed.push_back(make_req(ACT_LOOKUP, 32'h1234_5678, 6'd0, 32'h0, 4'd0));
      directed.push_back(make_req(ACT_INSERT, 32'hFFFF_FFFF, 6'd32, 32'hFFFF_FFFF, 4'd15));
      directed.push_back(make_req(ACT_LOOKUP, 32'hFFFF_FFFF, 6'd0, 32'h0, 4'd0));
      directed.push_back(make_req(ACT_LOOKUP, 32'hFFFF_FFFE, 6'd0, 32'h0, 4'd0));
      directed.push_back(make_req(ACT_INSERT, 32'h0000_0000, 6'd32, 32'h0000_0000, 4'd0));
      directed.push_back(make_req(ACT_LOOKUP, 32'h0000_0000, 6'd32, 32'h0, 4'd0));
      // host bits below the prefix length must not matter
      directed.push_back(make_req(ACT_INSERT, 32'h0A00_00FF, 6'd8, 32'h0A0A_0A0A, 4'd5));
      directed.push_back(make_req(ACT_LOOKUP, 32'h0AFF_FFFF, 6'd0, 32'h0, 4'd0));
      // same prefix again overwrites hop and port
      directed.push_back(make_req(ACT_INSERT, 32'h0A00_0000, 6'd8, 32'h0B0B_0B0B, 4'd6));
      directed.push_back(make_req(ACT_LOOKUP, 32'h0A12_3456, 6'd0, 32'h0, 4'd0));
      // lengths past 32 act as 32
      directed.push_back(make_req(ACT_INSERT, 32'h8000_0001, 6'd63, 32'hC0A8_0001, 4'd9));
      directed.push_back(make_req(ACT_LOOKUP, 32'h8000_0001, 6'd0, 32'h0, 4'd0));
      directed.push_back(make_req(ACT_LOOKUP, 32'h8000_0000, 6'd0, 32'h0, 4'd0));
      directed.push_back(make_req(ACT_INSERT, 32'h8000_0000, 6'd1, 32'h2222_2222, 4'd2));
      directed.push_back(make_req(ACT_LOOKUP, 32'h8000_0000, 6'd0, 32'h0, 4'd0));
      directed.push_back(make_req(ACT_LOOKUP, 32'h8000_0001, 6'd0, 32'h0, 4'd0));
      directed.push_back(make_req(ACT_INSERT, 32'hC000_0000, 6'd33, 32'h5555_AAAA, 4'd10));
      directed.push_back(make_req(ACT_LOOKUP, 32'hC000_0000, 6'd0, 32'h0, 4'd0));
      directed.push_back(make_req(ACT_LOOKUP, 32'hC000_0001, 6'd0, 32'h0, 4'd0));

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed[i]) send_item(directed[i]);

      for (int idx = 0; idx < ITEM_TARGET - directed.size(); idx++) begin
         if (idx == 250) hold_request = 1;
         if (idx == 700 && route_model.pending_answers.size() != 0) begin
            req_tvalid <= 1'b0;
            while (route_model.pending_answers.size() != 0) @(negedge clock);
         end
         if (idx >= ITEM_TARGET - directed.size() - CALM_TAIL) calm = 1;
         send_item(random_item(idx));
      end
      req_tvalid <= 1'b0;

      while (route_model.pending_answers.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (route_model.errors == 0 && route_model.pending_answers.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
